>>> rtl/core/csd_pkg.sv
package csd_pkg;

   localparam int unsigned CSD_ENTRIES = 32;

   localparam int unsigned CSR_INDEX_W = 2;
   localparam int unsigned CSR_DATA_W  = 16;

   localparam logic [CSR_INDEX_W-1:0] CSR_WINDOW    = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_THRESHOLD = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_RECOVER   = 2'd2;

   localparam logic [15:0] WINDOW_RESET    = 16'd60;
   localparam logic [7:0]  THRESHOLD_RESET = 8'd5;
   localparam logic [15:0] RECOVER_RESET   = 16'd300;

   localparam logic [7:0]  COUNT_MAX       = 8'hFF;
   localparam logic [63:0] IPV4_UPPER_MASK = 64'hFFFF_FFFF_0000_0000;

   localparam int unsigned REQ_DATA_W = 160;
   localparam int unsigned RSP_DATA_W = 8;

   typedef struct packed {
      logic        family;
      logic [63:0] addr_upper;
      logic [63:0] addr_lower;
      logic [31:0] first_time;
      logic [31:0] last_time;
      logic [7:0]  flip_count;
      logic        suppressed;
   } csd_entry_type;

   typedef struct packed {
      logic storm_resolved;
      logic storm_started;
      logic suppress;
   } csd_result_type;

endpackage

>>> rtl/core/conflict_storm_detector.sv
// Address conflict storm detector. Each request item is one address flip
// event (family in req_tuser, address and timestamp in req_tdata) and gives
// exactly one response item with the suppress / storm_started /
// storm_resolved flags. The tracking table lives in a memory with one read
// port and one write port that is scanned one entry per cycle; a scan stops
// at the first match, so a hit ends it early and a miss scans every entry.
// The entry is then updated in the table and the flags are registered as
// the response. The next item can be accepted in the same cycle as the
// response is offered; a new response waits while an earlier one is unread.
// req_tready is high only while no item is in work.
// Reset clears the table at once through per-entry valid bits. The csr port
// is always ready and must be written only while no item is in work.
module conflict_storm_detector #(
   parameter int unsigned ENTRIES = csd_pkg::CSD_ENTRIES
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_tvalid,
   output logic                             req_tready,
   // addr_upper[63:0], addr_lower[127:64], now_seconds[159:128]
   input  logic [csd_pkg::REQ_DATA_W-1:0]   req_tdata,
   // is_ipv6[0]
   input  logic                             req_tuser,
   output logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   // suppress[0], storm_started[1], storm_resolved[2], zero[7:3]
   output logic [csd_pkg::RSP_DATA_W-1:0]   rsp_tdata,
   input  logic                             csr_valid,
   output logic                             csr_ready,
   input  logic [csd_pkg::CSR_INDEX_W-1:0]  csr_index,
   input  logic [csd_pkg::CSR_DATA_W-1:0]   csr_data
);
   import csd_pkg::*;

   localparam int unsigned IDX_W = $clog2(ENTRIES);
   localparam int unsigned CNT_W = $clog2(ENTRIES + 1);
   localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(ENTRIES - 1);

   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_SCAN = 2'd1;
   localparam logic [1:0] ST_UPD  = 2'd2;
   localparam logic [1:0] ST_HOLD = 2'd3;

   logic [1:0]     state_ff, state_in;
   logic [15:0]    window_ff, window_in;
   logic [7:0]     thresh_ff, thresh_in;
   logic [15:0]    recover_ff, recover_in;

   logic           fam_ff, fam_in;
   logic [63:0]    up_ff, up_in;
   logic [63:0]    lo_ff, lo_in;
   logic [31:0]    now_ff, now_in;

   logic [CNT_W-1:0] issue_ff, issue_in;
   logic           chk_vld_ff, chk_vld_in;
   logic [IDX_W-1:0] chk_idx_ff, chk_idx_in;

   logic           have_empty_ff, have_empty_in;
   logic [IDX_W-1:0] empty_ff, empty_in;
   logic           have_old_ff, have_old_in;
   logic [IDX_W-1:0] oldest_ff, oldest_in;
   logic [31:0]    oldest_time_ff, oldest_time_in;
   logic           hit_ff, hit_in;
   logic [IDX_W-1:0] hit_idx_ff, hit_idx_in;
   csd_entry_type  hit_ent_ff, hit_ent_in;

   csd_result_type pend_ff, pend_in;
   logic           rsp_valid_ff, rsp_valid_in;
   csd_result_type rsp_res_ff, rsp_res_in;

   logic           rd_en;
   logic [IDX_W-1:0] rd_addr;
   csd_entry_type  rd_data;
   logic           rd_valid;
   logic           wr_en;
   logic [IDX_W-1:0] wr_addr;
   csd_entry_type  wr_data;

   logic           req_acc;
   logic           ent_free;
   logic           ent_match;
   csd_entry_type  fill_ent;
   csd_entry_type  upd_ent;
   csd_result_type upd_res;
   logic [31:0]    since_last;
   logic [31:0]    since_first;
   logic [7:0]     new_count;

   csd_table #(
      .ENTRIES (ENTRIES),
      .IDX_W   (IDX_W)
   ) u_table (
      .clock    (clock),
      .reset    (reset),
      .rd_en    (rd_en),
      .rd_addr  (rd_addr),
      .rd_data  (rd_data),
      .rd_valid (rd_valid),
      .wr_en    (wr_en),
      .wr_addr  (wr_addr),
      .wr_data  (wr_data)
   );

   assign req_tready = (state_ff == ST_IDLE);
   assign req_acc    = req_tvalid && req_tready;
   assign csr_ready  = 1'b1;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {(RSP_DATA_W - 3)'(0), rsp_res_ff};

   // config registers
   always_comb begin
      window_in  = window_ff;
      thresh_in  = thresh_ff;
      recover_in = recover_ff;
      if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_WINDOW: begin
               window_in = csr_data;
            end
            CSR_THRESHOLD: begin
               thresh_in = csr_data[7:0];
            end
            CSR_RECOVER: begin
               recover_in = csr_data;
            end
            default: begin
            end
         endcase
      end
   end

   // entry compare
   assign ent_free  = !rd_valid || (rd_data.flip_count == 8'd0);
   assign ent_match = (rd_data.family == fam_ff) && (rd_data.addr_upper == up_ff)
                      && (rd_data.addr_lower == lo_ff);

   assign rd_en   = (state_ff == ST_SCAN) && (issue_ff < CNT_W'(ENTRIES));
   assign rd_addr = issue_ff[IDX_W-1:0];

   // update arithmetic
   always_comb begin
      fill_ent.family     = fam_ff;
      fill_ent.addr_upper = up_ff;
      fill_ent.addr_lower = lo_ff;
      fill_ent.first_time = now_ff;
      fill_ent.last_time  = now_ff;
      fill_ent.flip_count = 8'd1;
      fill_ent.suppressed = 1'b0;

      since_last  = now_ff - hit_ent_ff.last_time;
      since_first = now_ff - hit_ent_ff.first_time;
      upd_ent     = hit_ent_ff;
      upd_res     = '0;
      new_count   = hit_ent_ff.flip_count;

      if (!hit_ff) begin
         upd_ent = fill_ent;
      end else if (hit_ent_ff.suppressed) begin
         if (since_last >= {16'd0, recover_ff}) begin
            upd_ent = fill_ent;
            upd_res.storm_resolved = 1'b1;
         end else begin
            upd_ent.last_time = now_ff;
            upd_res.suppress  = 1'b1;
         end
      end else begin
         if (since_first > {16'd0, window_ff}) begin
            upd_ent.first_time = now_ff;
            new_count = 8'd1;
         end else if (hit_ent_ff.flip_count != COUNT_MAX) begin
            new_count = hit_ent_ff.flip_count + 8'd1;
         end
         upd_ent.flip_count = new_count;
         upd_ent.last_time  = now_ff;
         if (new_count >= thresh_ff) begin
            upd_ent.suppressed    = 1'b1;
            upd_res.suppress      = 1'b1;
            upd_res.storm_started = 1'b1;
         end
      end
   end

   assign wr_en   = (state_ff == ST_UPD);
   assign wr_addr = hit_ff ? hit_idx_ff : (have_empty_ff ? empty_ff : oldest_ff);
   assign wr_data = upd_ent;

   // sequencer
   always_comb begin
      state_in       = state_ff;
      fam_in         = fam_ff;
      up_in          = up_ff;
      lo_in          = lo_ff;
      now_in         = now_ff;
      issue_in       = issue_ff;
      chk_vld_in     = 1'b0;
      chk_idx_in     = rd_addr;
      have_empty_in  = have_empty_ff;
      empty_in       = empty_ff;
      have_old_in    = have_old_ff;
      oldest_in      = oldest_ff;
      oldest_time_in = oldest_time_ff;
      hit_in         = hit_ff;
      hit_idx_in     = hit_idx_ff;
      hit_ent_in     = hit_ent_ff;
      pend_in        = pend_ff;
      rsp_valid_in   = rsp_valid_ff && !rsp_tready;
      rsp_res_in     = rsp_res_ff;

      case (state_ff)
         ST_IDLE: begin
            if (req_acc) begin
               fam_in        = req_tuser;
               up_in         = req_tuser ? req_tdata[63:0]
                                         : (req_tdata[63:0] & IPV4_UPPER_MASK);
               lo_in         = req_tuser ? req_tdata[127:64] : 64'd0;
               now_in        = req_tdata[159:128];
               issue_in      = '0;
               have_empty_in = 1'b0;
               have_old_in   = 1'b0;
               hit_in        = 1'b0;
               state_in      = ST_SCAN;
            end
         end
         ST_SCAN: begin
            chk_vld_in = rd_en;
            if (rd_en) begin
               issue_in = issue_ff + CNT_W'(1);
            end
            if (chk_vld_ff) begin
               if (ent_free) begin
                  if (!have_empty_ff) begin
                     have_empty_in = 1'b1;
                     empty_in      = chk_idx_ff;
                  end
               end else if (ent_match) begin
                  hit_in     = 1'b1;
                  hit_idx_in = chk_idx_ff;
                  hit_ent_in = rd_data;
                  state_in   = ST_UPD;
               end else if (!have_old_ff || (rd_data.last_time < oldest_time_ff)) begin
                  have_old_in    = 1'b1;
                  oldest_in      = chk_idx_ff;
                  oldest_time_in = rd_data.last_time;
               end
               if (chk_idx_ff == LAST_IDX) begin
                  state_in = ST_UPD;
               end
            end
         end
         ST_UPD: begin
            pend_in  = upd_res;
            state_in = ST_HOLD;
         end
         ST_HOLD: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in = 1'b1;
               rsp_res_in   = pend_ff;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         window_ff    <= WINDOW_RESET;
         thresh_ff    <= THRESHOLD_RESET;
         recover_ff   <= RECOVER_RESET;
         chk_vld_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         window_ff    <= window_in;
         thresh_ff    <= thresh_in;
         recover_ff   <= recover_in;
         chk_vld_ff   <= chk_vld_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      fam_ff         <= fam_in;
      up_ff          <= up_in;
      lo_ff          <= lo_in;
      now_ff         <= now_in;
      issue_ff       <= issue_in;
      chk_idx_ff     <= chk_idx_in;
      have_empty_ff  <= have_empty_in;
      empty_ff       <= empty_in;
      have_old_ff    <= have_old_in;
      oldest_ff      <= oldest_in;
      oldest_time_ff <= oldest_time_in;
      hit_ff         <= hit_in;
      hit_idx_ff     <= hit_idx_in;
      hit_ent_ff     <= hit_ent_in;
      pend_ff        <= pend_in;
      rsp_res_ff     <= rsp_res_in;
   end

`ifndef SYNTHESIS
   a_accept_starts_scan: assert property (@(posedge clock) disable iff (reset)
      req_acc |=> (state_ff == ST_SCAN))
      else $error("accepted item did not start a scan");

   a_write_only_in_update: assert property (@(posedge clock) disable iff (reset)
      wr_en |-> (state_ff == ST_UPD))
      else $error("table written outside update");

   a_miss_has_victim: assert property (@(posedge clock) disable iff (reset)
      ((state_ff == ST_UPD) && !hit_ff) |-> (have_empty_ff || have_old_ff))
      else $error("miss with neither free slot nor victim");

   a_started_implies_suppress: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_res_ff.storm_started) |-> rsp_res_ff.suppress)
      else $error("storm start without suppress");

   a_resolved_not_suppressed: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_res_ff.storm_resolved) |-> !rsp_res_ff.suppress)
      else $error("resolved item marked suppressed");
`endif

endmodule

>>> rtl/core/csd_table.sv
module csd_table #(
   parameter int unsigned ENTRIES = csd_pkg::CSD_ENTRIES,
   parameter int unsigned IDX_W   = $clog2(ENTRIES)
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  rd_en,
   input  logic [IDX_W-1:0]      rd_addr,
   output csd_pkg::csd_entry_type rd_data,
   output logic                  rd_valid,
   input  logic                  wr_en,
   input  logic [IDX_W-1:0]      wr_addr,
   input  csd_pkg::csd_entry_type wr_data
);
   import csd_pkg::*;

   csd_entry_type      entry_mem_ff [ENTRIES];
   logic [ENTRIES-1:0] valid_ff;
   logic [ENTRIES-1:0] valid_in;
   csd_entry_type      rd_data_ff;
   logic               rd_valid_ff;

   always_comb begin
      valid_in = valid_ff;
      if (wr_en) begin
         valid_in[wr_addr] = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         entry_mem_ff[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff  <= entry_mem_ff[rd_addr];
         rd_valid_ff <= valid_ff[rd_addr];
      end
   end

   assign rd_data  = rd_data_ff;
   assign rd_valid = rd_valid_ff;

endmodule

>>> sim/testbench.sv
`timescale 1ns / 100ps

module testbench;
   import csd_pkg::*;

   typedef struct packed {
      logic           is_ipv6;
      logic [63:0]    addr_upper;
      logic [63:0]    addr_lower;
      logic [31:0]    now_seconds;
      logic           typed;
      csd_result_type result;
   } flip_row_type;

   // result fields are resolved, started, suppress from the top bit down
   localparam flip_row_type DIRECTED_ROWS [16] = '{
      '{1'b0, 64'hC0A8_0001_0000_0000, 64'h0, 32'd100, 1'b1, 3'b000},
      '{1'b0, 64'hC0A8_0001_DEAD_BEEF, 64'hFFFF_FFFF_FFFF_FFFF, 32'd101, 1'b0, 3'b000},
      '{1'b0, 64'hC0A8_0001_0000_0001, 64'h1234_5678_9ABC_DEF0, 32'd102, 1'b0, 3'b000},
      '{1'b0, 64'hC0A8_0001_FFFF_FFFF, 64'h0, 32'd103, 1'b0, 3'b000},
      '{1'b0, 64'hC0A8_0001_0000_0000, 64'h0, 32'd104, 1'b1, 3'b011},
      '{1'b0, 64'hC0A8_0001_0000_0000, 64'h0, 32'd200, 1'b1, 3'b001},
      '{1'b0, 64'hC0A8_0001_0000_0000, 64'h0, 32'd500, 1'b1, 3'b100},
      '{1'b1, 64'hFFFF_FFFF_FFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF, 32'd500, 1'b1, 3'b000},
      '{1'b1, 64'hFFFF_FFFF_FFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF, 32'hFFFF_FFFF, 1'b0, 3'b000},
      '{1'b1, 64'hFFFF_FFFF_FFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF, 32'h0000_0010, 1'b0, 3'b000},
      '{1'b1, 64'h0, 64'h0, 32'd0, 1'b1, 3'b000},
      '{1'b0, 64'h0, 64'h0, 32'd0, 1'b1, 3'b000},
      '{1'b1, 64'hC0A8_0001_0000_0000, 64'h0, 32'd600, 1'b0, 3'b000},
      '{1'b0, 64'h0A00_0001_0000_0000, 64'h0, 32'd1000, 1'b0, 3'b000},
      '{1'b0, 64'h0A00_0001_0000_0000, 64'h0, 32'd1060, 1'b0, 3'b000},
      '{1'b0, 64'h0A00_0001_0000_0000, 64'h0, 32'd1061, 1'b0, 3'b000}
   };

   logic                    clock;
   logic                    reset       = 1'b1;
   logic                    req_tvalid  = 1'b0;
   logic                    req_tready;
   logic [REQ_DATA_W-1:0]   req_tdata   = '0;
   logic                    req_tuser   = 1'b0;
   logic                    rsp_tvalid;
   logic                    rsp_tready  = 1'b0;
   logic [RSP_DATA_W-1:0]   rsp_tdata;
   logic                    csr_valid   = 1'b0;
   logic                    csr_ready;
   logic [CSR_INDEX_W-1:0]  csr_index   = '0;
   logic [CSR_DATA_W-1:0]   csr_data    = '0;

   csd_entry_type   flip_table [CSD_ENTRIES];
   logic [15:0]     cfg_window;
   logic [7:0]      cfg_threshold;
   logic [15:0]     cfg_recover;

   csd_result_type  flips_expected [$];
   int unsigned     items_sent   = 0;
   int unsigned     results_seen = 0;
   int unsigned     mismatches   = 0;
   bit              hold_wanted  = 1'b0;
   bit              hold_done    = 1'b0;
   logic [31:0]     event_clock  = 32'd0;

   logic            pool_fam   [40];
   logic [63:0]     pool_upper [40];
   logic [63:0]     pool_lower [40];

   conflict_storm_detector dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   initial begin
      #10_000_000;
      $display("Simulation FAILED");
      $finish;
   end

   function automatic int idle_mode();
      if (items_sent < 470) return 0;
      if (items_sent < 940) return 1;
      return 2;
   endfunction

   function automatic csd_result_type predict_flip(input logic fam,
                                                   input logic [63:0] up_in,
                                                   input logic [63:0] lo_in,
                                                   input logic [31:0] now_s);
      csd_result_type res;
      logic [63:0]    up;
      logic [63:0]    lo;
      logic [31:0]    old_time;
      logic [31:0]    elapsed;
      bit             have_free;
      bit             have_old;
      bit             found;
      int unsigned    free_slot;
      int unsigned    old_slot;
      int unsigned    hit_slot;
      int unsigned    slot;
      res       = '0;
      up        = fam ? up_in : (up_in & IPV4_UPPER_MASK);
      lo        = fam ? lo_in : 64'd0;
      have_free = 1'b0;
      have_old  = 1'b0;
      found     = 1'b0;
      free_slot = 0;
      old_slot  = 0;
      hit_slot  = 0;
      old_time  = '0;
      for (int i = 0; i < CSD_ENTRIES && !found; i++) begin
         if (flip_table[i].flip_count == 8'd0) begin
            if (!have_free) begin
               have_free = 1'b1;
               free_slot = i;
            end
         end else if (flip_table[i].family == fam && flip_table[i].addr_upper == up &&
                      flip_table[i].addr_lower == lo) begin
            found    = 1'b1;
            hit_slot = i;
         end else if (!have_old || flip_table[i].last_time < old_time) begin
            have_old = 1'b1;
            old_time = flip_table[i].last_time;
            old_slot = i;
         end
      end
      if (found && flip_table[hit_slot].suppressed) begin
         elapsed = now_s - flip_table[hit_slot].last_time;
         if (elapsed >= {16'd0, cfg_recover}) begin
            flip_table[hit_slot] = '{fam, up, lo, now_s, now_s, 8'd1, 1'b0};
            res.storm_resolved = 1'b1;
         end else begin
            flip_table[hit_slot].last_time = now_s;
            res.suppress = 1'b1;
         end
      end else if (found) begin
         elapsed = now_s - flip_table[hit_slot].first_time;
         if (elapsed > {16'd0, cfg_window}) begin
            flip_table[hit_slot].first_time = now_s;
            flip_table[hit_slot].flip_count = 8'd1;
         end else if (flip_table[hit_slot].flip_count < COUNT_MAX) begin
            flip_table[hit_slot].flip_count = flip_table[hit_slot].flip_count + 8'd1;
         end
         flip_table[hit_slot].last_time = now_s;
         if (flip_table[hit_slot].flip_count >= cfg_threshold) begin
            flip_table[hit_slot].suppressed = 1'b1;
            res.suppress      = 1'b1;
            res.storm_started = 1'b1;
         end
      end else begin
         slot = have_free ? free_slot : old_slot;
         flip_table[slot] = '{fam, up, lo, now_s, now_s, 8'd1, 1'b0};
      end
      return res;
   endfunction

   task automatic offer_flip(input logic fam, input logic [63:0] up, input logic [63:0] lo,
                             input logic [31:0] now_s, input bit typed,
                             input csd_result_type typed_result);
      csd_result_type predicted;
      int unsigned    idle_pct;
      idle_pct = (idle_mode() == 0) ? 27 : (idle_mode() == 1) ? 82 : 0;
      @(negedge clock);
      while ($urandom_range(99, 0) < idle_pct) begin
         req_tvalid <= 1'b0;
         @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= fam;
      req_tdata  <= {now_s, lo, up};
      do @(posedge clock); while (!req_tready);
      predicted = predict_flip(fam, up, lo, now_s);
      flips_expected.push_back(typed ? typed_result : predicted);
      items_sent++;
   endtask

   task automatic settle_idle();
      @(negedge clock);
      req_tvalid <= 1'b0;
      while (flips_expected.size() != 0) @(posedge clock);
      repeat (40) @(posedge clock);
   endtask

   task automatic write_csr(input logic [CSR_INDEX_W-1:0] idx,
                            input logic [CSR_DATA_W-1:0] value);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= value;
      do @(posedge clock); while (!csr_ready);
      case (idx)
         CSR_WINDOW:    cfg_window    = value;
         CSR_THRESHOLD: cfg_threshold = value[7:0];
         CSR_RECOVER:   cfg_recover   = value;
         default: ;
      endcase
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   task automatic run_storm_phase(input int n_items, input int pool_n, input int max_dt,
                                  input int noise_pct, input int jump_pct);
      logic        fam;
      logic [63:0] up;
      logic [63:0] lo;
      int          k;
      for (int i = 0; i < pool_n; i++) begin
         pool_fam[i]   = 1'($urandom_range(1, 0));
         pool_upper[i] = {$urandom, $urandom};
         pool_lower[i] = {$urandom, $urandom};
      end
      for (int n = 0; n < n_items; n++) begin
         if ($urandom_range(99, 0) < noise_pct) begin
            fam = 1'($urandom_range(1, 0));
            up  = {$urandom, $urandom};
            lo  = {$urandom, $urandom};
         end else begin
            k   = $urandom_range(pool_n - 1, 0);
            fam = pool_fam[k];
            up  = pool_upper[k];
            lo  = pool_lower[k];
            if (!fam) begin
               up[31:0] = $urandom;
               lo       = {$urandom, $urandom};
            end
         end
         if ($urandom_range(99, 0) < jump_pct) event_clock = $urandom;
         else event_clock = event_clock + $urandom_range(max_dt, 0);
         offer_flip(fam, up, lo, event_clock, 1'b0, '0);
      end
      settle_idle();
   endtask

   task automatic note_mismatch(input string msg);
      mismatches++;
      if (mismatches <= 10) $display("%s", msg);
   endtask

   initial begin
      csd_result_type want;
      forever begin
         @(posedge clock);
         if (!reset && rsp_tvalid && rsp_tready) begin
            results_seen++;
            if (results_seen == 120) hold_wanted = 1'b1;
            if (flips_expected.size() == 0) begin
               note_mismatch($sformatf("unexpected result item, tdata=%02h", rsp_tdata));
            end else begin
               want = flips_expected.pop_front();
               if (rsp_tdata !== {5'd0, want}) begin
                  note_mismatch($sformatf(
                     "result %0d: expected suppress=%0b started=%0b resolved=%0b, got %02h",
                     results_seen, want.suppress, want.storm_started, want.storm_resolved,
                     rsp_tdata));
               end
            end
         end
      end
   end

   // long receiver hold-off so the block backs up and stalls its input
   initial begin
      int unsigned idle_pct;
      forever begin
         @(negedge clock);
         if (hold_wanted && !hold_done) begin
            hold_done = 1'b1;
            rsp_tready <= 1'b0;
            repeat (400) @(negedge clock);
         end
         idle_pct = (idle_mode() == 0) ? 82 : (idle_mode() == 1) ? 27 : 0;
         rsp_tready <= ($urandom_range(99, 0) >= idle_pct);
      end
   end

   initial begin
      for (int i = 0; i < CSD_ENTRIES; i++) flip_table[i] = '0;
      cfg_window    = WINDOW_RESET;
      cfg_threshold = THRESHOLD_RESET;
      cfg_recover   = RECOVER_RESET;

      repeat (12) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      foreach (DIRECTED_ROWS[r]) begin
         offer_flip(DIRECTED_ROWS[r].is_ipv6, DIRECTED_ROWS[r].addr_upper,
                    DIRECTED_ROWS[r].addr_lower, DIRECTED_ROWS[r].now_seconds,
                    DIRECTED_ROWS[r].typed, DIRECTED_ROWS[r].result);
      end
      settle_idle();

      // zero window and recovery, storm on the second flip
      write_csr(CSR_WINDOW, 16'd0);
      write_csr(CSR_THRESHOLD, 16'd1);
      write_csr(CSR_RECOVER, 16'd0);
      run_storm_phase(250, 4, 2, 5, 2);

      // one hot address driven up to the count limit
      write_csr(CSR_WINDOW, 16'hFFFF);
      write_csr(CSR_THRESHOLD, {8'($urandom_range(255, 0)), 8'hFF});
      write_csr(CSR_RECOVER, 16'hFFFF);
      run_storm_phase(320, 1, 3, 5, 0);

      // threshold zero and more addresses than slots
      write_csr(CSR_WINDOW, 16'd10);
      write_csr(CSR_THRESHOLD, 16'd0);
      write_csr(CSR_RECOVER, 16'd20);
      run_storm_phase(300, 40, 3, 10, 2);

      write_csr(CSR_WINDOW, 16'($urandom_range(200, 0)));
      write_csr(CSR_THRESHOLD, 16'($urandom_range(8, 1)));
      write_csr(CSR_RECOVER, 16'($urandom_range(300, 0)));
      run_storm_phase(300, 36, 20, 10, 3);

      write_csr(CSR_WINDOW, 16'($urandom));
      write_csr(CSR_THRESHOLD, 16'($urandom));
      write_csr(CSR_RECOVER, 16'($urandom));
      run_storm_phase(230, 8, 5000, 50, 10);

      if (mismatches == 0 && flips_expected.size() == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

endmodule

>>> sim.f
rtl/core/csd_pkg.sv
rtl/core/csd_table.sv
rtl/core/conflict_storm_detector.sv
sim/testbench.sv
